// ===== rtl/pacg_pkg.sv =====
// ----------------------------------------------------------------------------
// pacg_pkg
// Shared types, constants and the winding update for the annulus gap test.
// ----------------------------------------------------------------------------
package pacg_pkg;

  localparam int MAX_SIDES_DEF = 16;
  localparam int CW            = 24;
  localparam int DW            = CW + 1;
  localparam int PW            = 2 * DW;
  localparam int SIDES_W       = 7;
  localparam int WIND_W        = 8;

  typedef enum logic [1:0] {
    CMD_LOAD_INNER = 2'd0,
    CMD_LOAD_OUTER = 2'd1,
    CMD_TEST       = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_Z_MIN       = 3'd0,
    CFG_Z_MAX       = 3'd1,
    CFG_INNER_R     = 3'd2,
    CFG_OUTER_CR    = 3'd3,
    CFG_INNER_SIDES = 3'd4,
    CFG_OUTER_SIDES = 3'd5,
    CFG_Z_TOL       = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic                  valid;
    logic                  outer;
    logic [SIDES_W-1:0]    idx;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
  } load_t;

  typedef struct packed {
    logic                   valid;
    logic signed [CW-1:0]   px;
    logic signed [CW-1:0]   py;
    logic signed [WIND_W-1:0] wind_o;
    logic signed [WIND_W-1:0] wind_i;
    logic                   pend_en;
    logic                   pend_outer;
    logic                   pend_up;
    logic                   pend_down;
    logic signed [PW-1:0]   pend_a;
    logic signed [PW-1:0]   pend_b;
  } token_t;

  // fold the pending edge of a word into its winding count
  function automatic token_t pacg_resolve(token_t t);
    token_t r;
    logic signed [WIND_W-1:0] step;
    r    = t;
    step = '0;
    if (t.pend_en) begin
      if (t.pend_up && (t.pend_a > t.pend_b)) step = WIND_W'(1);
      else if (t.pend_down && (t.pend_a < t.pend_b)) step = -WIND_W'(1);
    end
    if (t.pend_outer) r.wind_o = t.wind_o + step;
    else r.wind_i = t.wind_i + step;
    r.pend_en = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/polygon_annulus_containment_test.sv =====
// ----------------------------------------------------------------------------
// polygon_annulus_containment_test
// A tested point travels a row of edge cells, outer polygon first and inner
// polygon second, one cell per cycle; its result is registered after the last
// cell and then moves to the output register. Loads are written straight into
// the cells. While a test word is in the row the input stalls; the next word is
// taken as soon as its result reaches the output register.
// ----------------------------------------------------------------------------
module polygon_annulus_containment_test
  import pacg_pkg::*;
#(
  parameter int MAX_SIDES = MAX_SIDES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [CW-1:0]        cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_command,
  input  logic [SIDES_W-1:0]   in_vertex_index,
  input  logic signed [CW-1:0] in_coord_x,
  input  logic signed [CW-1:0] in_coord_y,
  input  logic signed [CW-1:0] in_coord_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_in_gap
);

  localparam int NCELL = 2 * MAX_SIDES;

  logic signed [CW-1:0] z_min_r, z_max_r;
  logic [CW-2:0]        inner_r_r, outer_cr_r;
  logic [SIDES_W-1:0]   inner_sides_r, outer_sides_r, n_in, n_out;
  logic [15:0]          z_tol_r;
  logic                 accept, start, screen_ok, move;
  logic                 busy_r, res_v_r, res_r, out_valid_r, out_gap_r;
  load_t                load;
  token_t               tok [NCELL+1];
  token_t               fin;
  cmd_t                 cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_min_r       <= '0;
      z_max_r       <= '0;
      inner_r_r     <= '0;
      outer_cr_r    <= '0;
      inner_sides_r <= SIDES_W'(1);
      outer_sides_r <= SIDES_W'(1);
      z_tol_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_Z_MIN:       z_min_r       <= cfg_wdata;
        CFG_Z_MAX:       z_max_r       <= cfg_wdata;
        CFG_INNER_R:     inner_r_r     <= cfg_wdata[CW-2:0];
        CFG_OUTER_CR:    outer_cr_r    <= cfg_wdata[CW-2:0];
        CFG_INNER_SIDES: inner_sides_r <= cfg_wdata[SIDES_W-1:0];
        CFG_OUTER_SIDES: outer_sides_r <= cfg_wdata[SIDES_W-1:0];
        CFG_Z_TOL:       z_tol_r       <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign n_in  = (inner_sides_r == '0) ? SIDES_W'(1) :
                 (inner_sides_r > SIDES_W'(MAX_SIDES)) ? SIDES_W'(MAX_SIDES) : inner_sides_r;
  assign n_out = (outer_sides_r == '0) ? SIDES_W'(1) :
                 (outer_sides_r > SIDES_W'(MAX_SIDES)) ? SIDES_W'(MAX_SIDES) : outer_sides_r;

  assign cmd      = cmd_t'(in_command);
  assign in_stall = busy_r;
  assign accept   = in_valid && !in_stall;
  assign start    = accept && (cmd == CMD_TEST);

  always_comb begin
    load.valid = accept && ((cmd == CMD_LOAD_INNER) || (cmd == CMD_LOAD_OUTER));
    load.outer = (cmd == CMD_LOAD_OUTER);
    load.idx   = in_vertex_index;
    load.x     = in_coord_x;
    load.y     = in_coord_y;
  end

  always_comb begin
    tok[0]            = '0;
    tok[0].valid      = start;
    tok[0].px         = in_coord_x;
    tok[0].py         = in_coord_y;
  end

  pacg_screen u_screen (
    .clk          (clk),
    .start        (start),
    .px           (in_coord_x),
    .py           (in_coord_y),
    .pz           (in_coord_z),
    .z_min        (z_min_r),
    .z_max        (z_max_r),
    .inner_radius (inner_r_r),
    .outer_cr     (outer_cr_r),
    .z_tol        (z_tol_r),
    .ok           (screen_ok)
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    pacg_cell #(
      .SEL_OUTER (g < MAX_SIDES),
      .IDX       ((g < MAX_SIDES) ? g : g - MAX_SIDES)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .load    (load),
      .n_sides ((g < MAX_SIDES) ? n_out : n_in),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  assign fin  = pacg_resolve(tok[NCELL]);
  assign move = res_v_r && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      res_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (start) busy_r <= 1'b1;
      else if (move) busy_r <= 1'b0;
      if (fin.valid) res_v_r <= 1'b1;
      else if (move) res_v_r <= 1'b0;
      if (move) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.valid) res_r <= screen_ok && (fin.wind_o != '0) && (fin.wind_i == '0);
    if (move) out_gap_r <= res_r;
  end

  assign out_valid  = out_valid_r;
  assign out_in_gap = out_gap_r;

endmodule

// ===== rtl/pacg_cell.sv =====
// ----------------------------------------------------------------------------
// pacg_cell
// One polygon edge: holds both end vertices, settles the previous edge and
// forms the cross product terms of its own edge for the passing word.
// ----------------------------------------------------------------------------
module pacg_cell
  import pacg_pkg::*;
#(
  parameter bit SEL_OUTER = 1'b0,
  parameter int IDX       = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  load_t              load,
  input  logic [SIDES_W-1:0] n_sides,
  input  token_t             tok_in,
  output token_t             tok_out
);

  logic signed [CW-1:0] x0_r, y0_r, x1_r, y1_r;
  logic signed [DW-1:0] dx, dy, dpx, dpy;
  logic signed [PW-1:0] prod_a, prod_b;
  token_t tok_r, tok_nxt;

  always_ff @(posedge clk) begin
    if (load.valid && (load.outer == SEL_OUTER)) begin
      if (load.idx == SIDES_W'(IDX)) begin
        x0_r <= load.x;
        y0_r <= load.y;
      end
      if (load.idx == SIDES_W'(IDX + 1)) begin
        x1_r <= load.x;
        y1_r <= load.y;
      end
    end
  end

  assign dx     = DW'(x1_r) - DW'(x0_r);
  assign dy     = DW'(y1_r) - DW'(y0_r);
  assign dpx    = DW'(tok_in.px) - DW'(x0_r);
  assign dpy    = DW'(tok_in.py) - DW'(y0_r);
  assign prod_a = PW'(dx) * PW'(dpy);
  assign prod_b = PW'(dpx) * PW'(dy);

  always_comb begin
    tok_nxt            = pacg_resolve(tok_in);
    tok_nxt.pend_en    = tok_in.valid && (SIDES_W'(IDX) < n_sides);
    tok_nxt.pend_outer = SEL_OUTER;
    tok_nxt.pend_up    = (y0_r <= tok_in.py) && (y1_r > tok_in.py);
    tok_nxt.pend_down  = (y0_r > tok_in.py) && (y1_r <= tok_in.py);
    tok_nxt.pend_a     = prod_a;
    tok_nxt.pend_b     = prod_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.px         <= tok_nxt.px;
    tok_r.py         <= tok_nxt.py;
    tok_r.wind_o     <= tok_nxt.wind_o;
    tok_r.wind_i     <= tok_nxt.wind_i;
    tok_r.pend_en    <= tok_nxt.pend_en;
    tok_r.pend_outer <= tok_nxt.pend_outer;
    tok_r.pend_up    <= tok_nxt.pend_up;
    tok_r.pend_down  <= tok_nxt.pend_down;
    tok_r.pend_a     <= tok_nxt.pend_a;
    tok_r.pend_b     <= tok_nxt.pend_b;
  end

  assign tok_out = tok_r;

endmodule

// ===== rtl/pacg_screen.sv =====
// ----------------------------------------------------------------------------
// pacg_screen
// Z slab and radial screen of a tested point, two register stages.
// ----------------------------------------------------------------------------
module pacg_screen
  import pacg_pkg::*;
(
  input  logic                 clk,
  input  logic                 start,
  input  logic signed [CW-1:0] px,
  input  logic signed [CW-1:0] py,
  input  logic signed [CW-1:0] pz,
  input  logic signed [CW-1:0] z_min,
  input  logic signed [CW-1:0] z_max,
  input  logic [CW-2:0]        inner_radius,
  input  logic [CW-2:0]        outer_cr,
  input  logic [15:0]          z_tol,
  output logic                 ok
);

  localparam int ZW  = CW + 2;
  localparam int SQW = 2 * CW;
  localparam int RW  = 2 * (CW - 1);

  logic signed [ZW-1:0] z_lo, z_hi, z_ext;
  logic [SQW-1:0] sqx_r, sqy_r;
  logic [RW-1:0]  ri2_r, ro2_r;
  logic           zok_r, ok_r;
  logic [SQW:0]   r2;
  logic signed [SQW-1:0] sqx, sqy;

  assign z_ext = ZW'(pz);
  assign z_lo  = ZW'(z_min) - ZW'(signed'({1'b0, z_tol}));
  assign z_hi  = ZW'(z_max) + ZW'(signed'({1'b0, z_tol}));
  assign sqx   = SQW'(px) * SQW'(px);
  assign sqy   = SQW'(py) * SQW'(py);

  always_ff @(posedge clk) begin
    if (start) begin
      sqx_r <= sqx;
      sqy_r <= sqy;
      ri2_r <= RW'(inner_radius) * RW'(inner_radius);
      ro2_r <= RW'(outer_cr) * RW'(outer_cr);
      zok_r <= !((z_ext < z_lo) || (z_ext > z_hi));
    end
  end

  assign r2 = (SQW + 1)'(sqx_r) + (SQW + 1)'(sqy_r);

  always_ff @(posedge clk) begin
    ok_r <= zok_r && (r2 >= (SQW + 1)'(ri2_r)) && (r2 <= (SQW + 1)'(ro2_r));
  end

  assign ok = ok_r;

endmodule
